>>> rtl/core/command_frame_validator_defines.svh
// assertion macros shared by the command frame validator
`ifndef COMMAND_FRAME_VALIDATOR_DEFINES_SVH
`define COMMAND_FRAME_VALIDATOR_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CFV_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CFV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cfv_pkg.sv
package cfv_pkg;

   // separator and control codes
   localparam logic [15:0] END_COMMAND = 16'h001E;
   localparam logic [15:0] END_PART    = 16'h001F;
   localparam logic [15:0] CTRL_MAX    = 16'h001F;
   localparam logic [15:0] DEL_CODE    = 16'h007F;
   localparam logic [15:0] CR_CODE     = 16'h000D;
   localparam logic [15:0] LF_CODE     = 16'h000A;
   localparam logic [15:0] TAB_CODE    = 16'h0009;

   // part index saturates here: name, key, room, then arguments
   localparam logic [1:0] ARG_PARTS = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] MAX_HEADER_LEN_RST = 16'd64;
   localparam logic [7:0]  ARG_LIMIT_RST      = 8'd4;
   localparam logic [15:0] MAX_ARG_LEN_RST    = 16'd10000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_HEADER_LEN = 2'd0,
      CSR_ARG_LIMIT      = 2'd1,
      CSR_MAX_ARG_LEN    = 2'd2
   } cfv_csr_type;

   typedef enum logic [2:0] {
      REASON_OK          = 3'd0,
      REASON_HDR_LONG    = 3'd1,
      REASON_HDR_ILLEGAL = 3'd2,
      REASON_ARG_COUNT   = 3'd3,
      REASON_BAD_ARG     = 3'd4
   } cfv_reason_type;

   typedef struct packed {
      logic [15:0] max_header_len;
      logic [7:0]  arg_limit;
      logic [15:0] max_arg_len;
   } cfv_cfg_type;

   typedef struct packed {
      logic           command_valid;
      cfv_reason_type fail_reason;
      logic [7:0]     arg_count;
      logic           last_of_text;
   } cfv_verdict_type;

   typedef struct packed {
      logic [1:0]                  count;
      cfv_verdict_type [1:0]       items;
   } cfv_push_type;

   typedef struct packed {
      logic not_empty;
      logic room_for_two;
   } cfv_queue_status_type;

   typedef struct packed {
      logic [1:0]  part_idx;
      logic [15:0] part_len;
      logic        hdr_long;
      logic        hdr_illegal;
      logic        arg_bad;
      logic [7:0]  args;
   } cfv_cmd_state_type;

   localparam cfv_cmd_state_type CMD_CLEAR = '0;

   function automatic cfv_verdict_type make_verdict(input cfv_cmd_state_type st,
                                                    input logic [7:0] max_args,
                                                    input logic last);
      cfv_verdict_type v;
      v.fail_reason = REASON_OK;
      if (st.hdr_long) begin
         v.fail_reason = REASON_HDR_LONG;
      end else if (st.hdr_illegal) begin
         v.fail_reason = REASON_HDR_ILLEGAL;
      end else if (st.args > max_args) begin
         v.fail_reason = REASON_ARG_COUNT;
      end else if (st.arg_bad) begin
         v.fail_reason = REASON_BAD_ARG;
      end
      v.command_valid = (v.fail_reason == REASON_OK);
      v.arg_count     = st.args;
      v.last_of_text  = last;
      return v;
   endfunction

endpackage

>>> rtl/core/cfv_channels.sv
interface cfv_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        has_char;
   logic        is_last;

   modport source (output valid, code_unit, has_char, is_last, input ready);
   modport sink (input valid, code_unit, has_char, is_last, output ready);
endinterface

interface cfv_rsp_if;
   logic       valid;
   logic       ready;
   logic       command_valid;
   logic [2:0] fail_reason;
   logic [7:0] arg_count;
   logic       last_of_text;

   modport source (output valid, command_valid, fail_reason, arg_count, last_of_text,
                   input ready);
   modport sink (input valid, command_valid, fail_reason, arg_count, last_of_text,
                 output ready);
endinterface

interface cfv_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/cfv_parser.sv
module cfv_parser import cfv_pkg::*; #(
   parameter int UNIT_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cfv_cfg_type       cfg,
   input  logic              fire,
   input  logic [UNIT_W-1:0] unit,
   input  logic              has_char,
   input  logic              is_last,
   output cfv_push_type      push
);

   cfv_cmd_state_type st_ff, st_in;

   function automatic logic unit_illegal(input logic [UNIT_W-1:0] c);
      logic ok_ws;
      ok_ws = (c == UNIT_W'(CR_CODE)) || (c == UNIT_W'(LF_CODE)) || (c == UNIT_W'(TAB_CODE));
      return !ok_ws && ((c <= UNIT_W'(CTRL_MAX)) || (c == UNIT_W'(DEL_CODE)));
   endfunction

   always_comb begin
      cfv_cmd_state_type st_take;
      cfv_cmd_state_type st_mid;
      logic              bad;
      st_take = st_ff;
      bad     = unit_illegal(unit);
      // effect of one ordinary character or a part separator
      if (unit == UNIT_W'(END_PART)) begin
         if (st_ff.part_idx != ARG_PARTS) begin
            st_take.part_idx = st_ff.part_idx + 2'd1;
         end
         if (st_take.part_idx == ARG_PARTS && st_ff.args != 8'hFF) begin
            st_take.args = st_ff.args + 8'd1;
         end
         st_take.part_len = '0;
      end else begin
         if (st_ff.part_len != 16'hFFFF) begin
            st_take.part_len = st_ff.part_len + 16'd1;
         end
         if (st_ff.part_idx != ARG_PARTS) begin
            if (st_take.part_len > cfg.max_header_len) st_take.hdr_long = 1'b1;
            if (bad) st_take.hdr_illegal = 1'b1;
         end else begin
            if (st_take.part_len > cfg.max_arg_len || bad) st_take.arg_bad = 1'b1;
         end
      end

      st_mid     = has_char ? st_take : st_ff;
      st_in      = st_ff;
      push.count = 2'd0;
      push.items[0] = make_verdict(st_mid, cfg.arg_limit, 1'b1);
      push.items[1] = make_verdict(CMD_CLEAR, cfg.arg_limit, 1'b1);

      if (fire) begin
         if (has_char && unit == UNIT_W'(END_COMMAND)) begin
            // verdict of the ended command, then the empty one on a last item
            push.items[0] = make_verdict(st_ff, cfg.arg_limit, 1'b0);
            push.count    = is_last ? 2'd2 : 2'd1;
            st_in         = CMD_CLEAR;
         end else if (is_last) begin
            push.count = 2'd1;
            st_in      = CMD_CLEAR;
         end else begin
            st_in = st_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CMD_CLEAR;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

>>> rtl/core/cfv_out_queue.sv
module cfv_out_queue import cfv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfv_push_type         push,
   input  logic                 pop,
   output cfv_verdict_type      head,
   output cfv_queue_status_type status
);

   cfv_verdict_type   entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic [QPTR_W:0]   count_after_pop;

   assign count_after_pop     = count_ff - (QPTR_W + 1)'(pop);
   assign status.not_empty    = (count_ff != '0);
   assign status.room_for_two = (count_after_pop <= (QPTR_W + 1)'(QUEUE_DEPTH - 2));
   assign head                = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_after_pop + (QPTR_W + 1)'(push.count);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.items[0];
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + QPTR_W'(1)] <= push.items[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/command_frame_validator.sv
// channel   direction   payload                                              handshake
// req_if    in          code_unit[15:0], has_char, is_last                   valid/ready
// rsp_if    out         command_valid, fail_reason[2:0], arg_count[7:0],     valid/ready
//                       last_of_text
// csr_if    in          index[1:0], data[15:0]                               valid/ready
//
// one item per cycle is accepted while the result queue has room for two verdicts
// a verdict reaches rsp_if through the input register and then the queue
// a separator on the last item gives two verdicts, which leave rsp_if one after the other
// reset is synchronous; no clearing pass is needed
// with rsp_if stalled, processing stops once three or more verdicts wait, then req_if.ready drops
`include "command_frame_validator_defines.svh"

module command_frame_validator import cfv_pkg::*; #(
   parameter int CHAR_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   cfv_req_if.sink   req_if,
   cfv_rsp_if.source rsp_if,
   cfv_csr_if.sink   csr_if
);

   // only the low CHAR_BITS bits of a code unit take part, at most 16
   localparam int UNIT_W = (CHAR_BITS < 16) ? CHAR_BITS : 16;

   // limits set through the csr channel
   cfv_cfg_type cfg_ff, cfg_in;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [UNIT_W-1:0] unit_ff;
   logic              has_ff;
   logic              last_ff;

   logic                 proc_fire;
   logic                 req_take;
   logic                 pop;
   cfv_push_type         push;
   cfv_verdict_type      head;
   cfv_queue_status_type q_status;

   // csr writes are always taken; an index past the list is ignored
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_MAX_HEADER_LEN: cfg_in.max_header_len = csr_if.data;
            CSR_ARG_LIMIT:      cfg_in.arg_limit      = csr_if.data[7:0];
            CSR_MAX_ARG_LEN:    cfg_in.max_arg_len    = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_header_len <= MAX_HEADER_LEN_RST;
         cfg_ff.arg_limit      <= ARG_LIMIT_RST;
         cfg_ff.max_arg_len    <= MAX_ARG_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the held item moves on once the queue can take both possible verdicts
   assign proc_fire    = in_valid_ff && q_status.room_for_two;
   assign req_if.ready = !in_valid_ff || proc_fire;
   assign req_take     = req_if.valid && req_if.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !proc_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload holds while the item waits
   always_ff @(posedge clock) begin
      if (req_take) begin
         unit_ff <= req_if.code_unit[UNIT_W-1:0];
         has_ff  <= req_if.has_char;
         last_ff <= req_if.is_last;
      end
   end

   // per-command state and verdict logic
   cfv_parser #(
      .UNIT_W(UNIT_W)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .fire     (proc_fire),
      .unit     (unit_ff),
      .has_char (has_ff),
      .is_last  (last_ff),
      .push     (push)
   );

   // verdicts wait here for the rsp side
   assign pop = rsp_if.valid && rsp_if.ready;

   cfv_out_queue u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   assign rsp_if.valid         = q_status.not_empty;
   assign rsp_if.command_valid = head.command_valid;
   assign rsp_if.fail_reason   = 3'(head.fail_reason);
   assign rsp_if.arg_count     = head.arg_count;
   assign rsp_if.last_of_text  = head.last_of_text;

   // a waiting item is never dropped
   `CFV_ASSERT_NEXT(a_item_held, in_valid_ff && !proc_fire, in_valid_ff, "held item lost")
   // verdict flag agrees with the reason code
   `CFV_ASSERT_IMPLY(a_verdict_match, rsp_if.valid,
      rsp_if.command_valid == (rsp_if.fail_reason == REASON_OK), "verdict flag mismatch")
   // no verdict before anything was processed after reset
   `CFV_ASSERT_IMPLY(a_empty_after_reset, $past(reset), !rsp_if.valid, "verdict after reset")
   // verdicts are only pushed by a processed item
   `CFV_ASSERT_IMPLY(a_push_needs_item, push.count != 2'd0, proc_fire, "stray verdict push")

endmodule
